// ===== rtl/liur_pkg.sv =====
// ----------------------------------------------------------------------------
// liur_pkg: shared constants and types of the uniform-grid resampler
// Widths, sample limit, register reset value and sequencer states.
// ----------------------------------------------------------------------------
package liur_pkg;

  localparam int unsigned MaxSamples = 64;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned GridW      = TimeW + 1;
  localparam int unsigned CntW       = $clog2(MaxSamples + 1);
  localparam int unsigned SpanW      = TimeW + CntW + 1;
  localparam int unsigned DivSteps   = GridW;
  localparam int unsigned DivCntW    = $clog2(DivSteps + 1);
  localparam int unsigned ProdW      = TimeW + GridW;

  localparam logic [TimeW-1:0] StepReset = 32'd167772;

  typedef enum logic [9:0] {
    SIdle     = 10'b00_0000_0001,
    SNext     = 10'b00_0000_0010,
    SMul0     = 10'b00_0000_0100,
    SMul1     = 10'b00_0000_1000,
    SDivStart = 10'b00_0001_0000,
    SDiv      = 10'b00_0010_0000,
    SRound    = 10'b00_0100_0000,
    SEmit     = 10'b00_1000_0000,
    SSkip     = 10'b01_0000_0000,
    SDone     = 10'b10_0000_0000
  } state_e;

  typedef enum logic {
    DivLerp = 1'b0,
    DivSkip = 1'b1
  } div_mode_e;

endpackage

// ===== rtl/linear_interp_uniform_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_uniform_resampler: breakpoint stream to uniform-grid samples
// Linear interpolation of (time, value) breakpoints at 0, step, 2*step, ...
// ----------------------------------------------------------------------------
// The first breakpoint of a curve is only recorded and emits nothing. Each
// later breakpoint yields its samples in turn, each by a 32x33 multiply
// (SMul0, SMul1), a 33-step restoring divider shared by all samples,
// rounding and the output load; a saturating quotient skips the divider,
// and a segment of zero or negative length emits the breakpoint's value.
// When more than 64 samples fall in one segment the extra ones are dropped,
// flagged on the segment's words, and a further pass of the same divider
// places the grid at or past the breakpoint. The input is stalled while a
// breakpoint is worked on; the output word register lets the next sample
// be prepared while one waits. The user writes sample_step through the cfg
// port only while the block is idle; the block itself does not enforce it.
module linear_interp_uniform_resampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic        [31:0]              cfg_sample_step_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic        [31:0]              point_time_i,
  input  logic signed [31:0]              point_value_i,
  input  logic                            final_point_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              sample_value_o,
  output logic                            run_end_o,
  output logic                            overflow_o
);

  localparam int unsigned TW = liur_pkg::TimeW;
  localparam int unsigned VW = liur_pkg::ValW;
  localparam int unsigned GW = liur_pkg::GridW;
  localparam int unsigned CW = liur_pkg::CntW;
  localparam int unsigned SW = liur_pkg::SpanW;
  localparam int unsigned DW = liur_pkg::DivCntW;
  localparam int unsigned PW = liur_pkg::ProdW;

  liur_pkg::state_e    state_q, state_d;
  liur_pkg::div_mode_e mode_q, mode_d;

  logic [TW-1:0] step_q, step_d;
  logic [TW-1:0] prev_time_q, prev_time_d;
  logic [VW-1:0] prev_value_q, prev_value_d;
  logic [GW-1:0] grid_q, grid_d;
  logic          primed_q, primed_d;
  logic [TW-1:0] t1_q, t1_d;
  logic [VW-1:0] x1_q, x1_d;
  logic          fin_q, fin_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] div_cnt_q, div_cnt_d;
  logic [TW-1:0] a_q, a_d;
  logic          dneg_q, dneg_d;
  logic          neg_q, neg_d;
  logic [GW-1:0] b_q, b_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [TW-1:0] rem_q, rem_d;
  logic [GW-1:0] num_q, num_d;
  logic [TW-1:0] den_q, den_d;
  logic          sat_q, sat_d;
  logic [VW-1:0] res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_value_q, out_value_d;
  logic          out_end_q, out_end_d;
  logic          out_ovf_q, out_ovf_d;

  logic          in_acc;
  logic [TW-1:0] step_eff;
  logic [TW:0]   dx;
  logic [GW:0]   dtau;
  logic [SW-1:0] span;
  logic          in_seg;
  logic          degen;
  logic [TW:0]   trial;
  logic          ge;
  logic [GW:0]   q;
  logic [GW+1:0] r;
  logic          out_free;
  logic [GW:0]   grid_nx;
  logic [2*TW-1:0] mul;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != liur_pkg::SIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign step_eff    = (step_q == '0) ? TW'(1) : step_q;

  assign dx     = {point_value_i[VW-1], point_value_i} - {prev_value_q[VW-1], prev_value_q};
  assign dtau   = {1'b0, grid_q} - {2'b00, prev_time_q};
  assign span   = SW'(grid_q) + SW'(step_eff) * SW'(liur_pkg::MaxSamples);
  assign in_seg = ({1'b0, t1_q} > grid_q) && (cnt_q < CW'(liur_pkg::MaxSamples));
  assign degen  = (t1_q <= prev_time_q);
  assign trial  = {rem_q, num_q[GW-1]};
  assign ge     = (trial >= {1'b0, den_q});
  assign q      = sat_q ? (GW+1)'({1'b1, {GW{1'b0}}})
                        : {1'b0, num_q} + (GW+1)'({rem_q, 1'b0} >= {1'b0, den_q});
  assign r      = {{3{prev_value_q[VW-1]}}, prev_value_q}
                + (neg_q ? -{1'b0, q} : {1'b0, q});
  assign out_free = !out_valid_q || !out_stall_i;
  assign grid_nx  = {1'b0, grid_q} + (GW+1)'(step_eff);
  assign mul      = a_q * b_q[TW-1:0];

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    step_d       = step_q;
    prev_time_d  = prev_time_q;
    prev_value_d = prev_value_q;
    grid_d       = grid_q;
    primed_d     = primed_q;
    t1_d         = t1_q;
    x1_d         = x1_q;
    fin_d        = fin_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    div_cnt_d    = div_cnt_q;
    a_d          = a_q;
    dneg_d       = dneg_q;
    neg_d        = neg_q;
    b_d          = b_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    num_d        = num_q;
    den_d        = den_q;
    sat_d        = sat_q;
    res_d        = res_q;
    out_value_d  = out_value_q;
    out_end_d    = out_end_q;
    out_ovf_d    = out_ovf_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cfg_valid_i && cfg_ready_o) begin
      step_d = cfg_sample_step_i;
    end

    unique case (state_q)
      liur_pkg::SIdle: begin
        if (in_acc) begin
          if (!primed_q) begin
            prev_time_d  = point_time_i;
            prev_value_d = point_value_i;
            grid_d       = '0;
            primed_d     = !final_point_i;
          end else begin
            t1_d    = point_time_i;
            x1_d    = point_value_i;
            fin_d   = final_point_i;
            dneg_d  = dx[TW];
            a_d     = dx[TW] ? TW'(-dx) : dx[TW-1:0];
            cnt_d   = '0;
            ovf_d   = span < SW'(point_time_i);
            state_d = liur_pkg::SNext;
          end
        end
      end
      liur_pkg::SNext: begin
        if (in_seg) begin
          if (degen) begin
            res_d   = x1_q;
            state_d = liur_pkg::SEmit;
          end else begin
            b_d     = dtau[GW] ? GW'(-dtau) : dtau[GW-1:0];
            neg_d   = dneg_q ^ dtau[GW];
            state_d = liur_pkg::SMul0;
          end
        end else if (ovf_q) begin
          den_d     = step_eff;
          rem_d     = '0;
          num_d     = {1'b0, t1_q - grid_q[TW-1:0]};
          div_cnt_d = DW'(liur_pkg::DivSteps);
          mode_d    = liur_pkg::DivSkip;
          state_d   = liur_pkg::SDiv;
        end else begin
          state_d = liur_pkg::SDone;
        end
      end
      liur_pkg::SMul0: begin
        prod_d  = PW'(mul);
        state_d = liur_pkg::SMul1;
      end
      liur_pkg::SMul1: begin
        prod_d  = prod_q + (b_q[GW-1] ? {1'b0, a_q, {TW{1'b0}}} : '0);
        state_d = liur_pkg::SDivStart;
      end
      liur_pkg::SDivStart: begin
        den_d     = t1_q - prev_time_q;
        sat_d     = prod_q[PW-1:GW] >= (t1_q - prev_time_q);
        rem_d     = prod_q[PW-1:GW];
        num_d     = prod_q[GW-1:0];
        div_cnt_d = DW'(liur_pkg::DivSteps);
        mode_d    = liur_pkg::DivLerp;
        state_d   = (prod_q[PW-1:GW] >= (t1_q - prev_time_q)) ? liur_pkg::SRound
                                                                : liur_pkg::SDiv;
      end
      liur_pkg::SDiv: begin
        rem_d     = ge ? TW'(trial - {1'b0, den_q}) : trial[TW-1:0];
        num_d     = {num_q[GW-2:0], ge};
        div_cnt_d = div_cnt_q - DW'(1);
        if (div_cnt_q == DW'(1)) begin
          state_d = (mode_q == liur_pkg::DivLerp) ? liur_pkg::SRound : liur_pkg::SSkip;
        end
      end
      liur_pkg::SRound: begin
        if (!r[GW+1] && (r[GW:VW-1] != '0)) begin
          res_d = {1'b0, {(VW-1){1'b1}}};
        end else if (r[GW+1] && (r[GW:VW-1] != '1)) begin
          res_d = {1'b1, {(VW-1){1'b0}}};
        end else begin
          res_d = r[VW-1:0];
        end
        state_d = liur_pkg::SEmit;
      end
      liur_pkg::SEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          out_ovf_d   = ovf_q;
          out_end_d   = (grid_nx >= (GW+1)'(t1_q))
                     || (cnt_q == CW'(liur_pkg::MaxSamples - 1));
          grid_d      = grid_nx[GW-1:0];
          cnt_d       = cnt_q + CW'(1);
          state_d     = liur_pkg::SNext;
        end
      end
      liur_pkg::SSkip: begin
        grid_d  = GW'({1'b0, t1_q} + ((rem_q == '0) ? '0 : {1'b0, step_eff - rem_q}));
        state_d = liur_pkg::SDone;
      end
      liur_pkg::SDone: begin
        prev_time_d  = t1_q;
        prev_value_d = x1_q;
        if (fin_q) begin
          primed_d = 1'b0;
          grid_d   = '0;
        end
        state_d = liur_pkg::SIdle;
      end
      default: begin
        state_d = liur_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= liur_pkg::SIdle;
      mode_q       <= liur_pkg::DivLerp;
      step_q       <= liur_pkg::StepReset;
      prev_time_q  <= '0;
      prev_value_q <= '0;
      grid_q       <= '0;
      primed_q     <= 1'b0;
      ovf_q        <= 1'b0;
      cnt_q        <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      step_q       <= step_d;
      prev_time_q  <= prev_time_d;
      prev_value_q <= prev_value_d;
      grid_q       <= grid_d;
      primed_q     <= primed_d;
      ovf_q        <= ovf_d;
      cnt_q        <= cnt_d;
      div_cnt_q    <= div_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q        <= t1_d;
    x1_q        <= x1_d;
    fin_q       <= fin_d;
    a_q         <= a_d;
    dneg_q      <= dneg_d;
    neg_q       <= neg_d;
    b_q         <= b_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    den_q       <= den_d;
    sat_q       <= sat_d;
    res_q       <= res_d;
    out_value_q <= out_value_d;
    out_end_q   <= out_end_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_value_q;
  assign run_end_o      = out_end_q;
  assign overflow_o     = out_ovf_q;

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(liur_pkg::MaxSamples))
    else $error("sample count past limit");

  a_emit_before_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == liur_pkg::SEmit) |-> (grid_q < {1'b0, t1_q}))
    else $error("grid time not before breakpoint on emit");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == liur_pkg::SDiv) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_unprimed_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == liur_pkg::SIdle && !primed_q) |-> (grid_q == '0))
    else $error("grid not at zero while unprimed");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for linear_interp_uniform_resampler
// Drives breakpoint curves under random input gaps and output stalls, predicts
// every grid sample in the bench, and compares each output word in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] S        = liur_pkg::StepReset;
  localparam logic [79:0] QuoCap   = 80'd1 << 33;
  localparam longint      ValMax   = 64'sh7FFF_FFFF;
  localparam longint      ValMin   = -64'sh8000_0000;
  localparam int          NumItems = 310;
  localparam int          Settle   = 100;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sample_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [31:0] cfg_step;
  logic               in_valid;
  logic               in_stall;
  logic        [31:0] pt_time;
  logic signed [31:0] pt_value;
  logic               pt_final;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] smp_value;
  logic               smp_run_end;
  logic               smp_overflow;

  // resampler state as the bench sees it
  logic        [31:0] grid_step = S;
  logic        [31:0] curve_prev_time = '0;
  logic signed [31:0] curve_prev_value = '0;
  logic        [32:0] grid_time = '0;
  bit                 curve_open = 1'b0;

  sample_t pending_samples[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      words_checked = 0;
  int      ovf_words = 0;
  int      steps_written = 0;
  int      hold_cycles = 0;

  linear_interp_uniform_resampler u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_sample_step_i (cfg_step),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .point_time_i      (pt_time),
    .point_value_i     (pt_value),
    .final_point_i     (pt_final),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .sample_value_o    (smp_value),
    .run_end_o         (smp_run_end),
    .overflow_o        (smp_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // value on the line (t0,x0)-(t1,x1) at grid time tg
  function automatic logic signed [31:0] interp_at(input logic [31:0] t0,
                                                   input logic signed [31:0] x0,
                                                   input logic [31:0] t1,
                                                   input logic signed [31:0] x1,
                                                   input logic [32:0] tg);
    longint      dx, dtau, r;
    logic [79:0] mag_dx, mag_dt, prod, den, quo, rem;
    bit          neg;
    if (t1 <= t0) return x1;
    den    = 80'(t1) - 80'(t0);
    dx     = longint'(x1) - longint'(x0);
    dtau   = longint'(tg) - longint'(t0);
    neg    = (dx < 0) != (dtau < 0);
    mag_dx = 80'(dx < 0 ? -dx : dx);
    mag_dt = 80'(dtau < 0 ? -dtau : dtau);
    prod   = mag_dx * mag_dt;
    quo    = prod / den;
    rem    = prod % den;
    if (quo >= QuoCap) quo = QuoCap;
    else if ((rem << 1) >= den) quo = quo + 80'd1;
    r = longint'(x0) + (neg ? -longint'(quo[63:0]) : longint'(quo[63:0]));
    if (r > ValMax) r = ValMax;
    if (r < ValMin) r = ValMin;
    return r[31:0];
  endfunction

  // expected words for one accepted breakpoint
  function automatic void resample_point(input logic [31:0] t1,
                                         input logic signed [31:0] x1,
                                         input logic fin);
    logic [63:0]        stride, grid64, skip;
    logic signed [31:0] vals[$];
    sample_t            w;
    bit                 ovf;
    stride = (grid_step == 0) ? 64'd1 : 64'(grid_step);
    if (!curve_open) begin
      curve_prev_time  = t1;
      curve_prev_value = x1;
      grid_time        = '0;
      curve_open       = !fin;
      return;
    end
    grid64 = 64'(grid_time);
    while (grid64 < 64'(t1) && vals.size() < liur_pkg::MaxSamples) begin
      vals.insert(vals.size(),
                  interp_at(curve_prev_time, curve_prev_value, t1, x1, grid64[32:0]));
      grid64 += stride;
    end
    ovf = grid64 < 64'(t1);
    if (ovf) begin
      skip = (64'(t1) - grid64 + stride - 1) / stride;
      grid64 += skip * stride;
    end
    grid_time = grid64[32:0];
    foreach (vals[k]) begin
      w.value = vals[k];
      w.last  = (k == vals.size() - 1);
      w.ovf   = ovf;
      pending_samples.insert(pending_samples.size(), w);
    end
    curve_prev_time  = t1;
    curve_prev_value = x1;
    if (fin) begin
      curve_open = 1'b0;
      grid_time  = '0;
    end
  endfunction

  task automatic send_point(input logic [31:0] t, input logic signed [31:0] v,
                            input logic fin, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pt_time  <= t;
    pt_value <= v;
    pt_final <= fin;
    do @(posedge clk); while (in_stall);
    resample_point(t, v, fin);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_step(input logic [31:0] s);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_step  <= s;
    do @(posedge clk); while (!cfg_ready);
    grid_step = s;
    steps_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one curve of n_pts breakpoints, times scaled to the grid step
  task automatic send_curve(input int n_pts, input logic [31:0] s, input bit burst);
    logic [63:0]        t, stride;
    logic [31:0]        back;
    logic [19:0]        d;
    logic signed [31:0] v;
    int                 r;
    stride = (s == 0) ? 64'd1 : 64'(s);
    v = $urandom;
    r = $urandom_range(0, 99);
    if (r < 70) t = stride * $urandom_range(0, 2) + $urandom_range(0, stride[31:0] - 1);
    else if (r < 90) t = '0;
    else t = 64'($urandom);
    for (int k = 0; k < n_pts; k++) begin
      if (k > 0) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          t += stride * $urandom_range(0, 3) + $urandom_range(0, stride[31:0] - 1);
        end else if (r < 92 && r >= 85) begin
          back = $urandom_range(0, stride[31:0]);
          t = (t > 64'(back)) ? t - 64'(back) : '0;
        end else if (r >= 92) begin
          t += stride * $urandom_range(60, 70);
        end
      end
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      r = $urandom_range(0, 99);
      d = $urandom;
      if (r < 60) v = v + {{12{d[19]}}, d};
      else if (r < 85) v = $urandom;
      else v = d[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      send_point(t[31:0], v, k == n_pts - 1, burst ? 0 : pick_gap());
    end
  endtask

  task automatic test_directed_points();
    send_point(32'd100, 32'sd7, 1'b1, pick_gap());
    send_point(S / 2, 32'sd1000, 1'b0, pick_gap());
    send_point(3 * S + 5, -32'sd50000, 1'b0, pick_gap());
    send_point(3 * S + 5, 32'sd123, 1'b0, pick_gap());
    send_point(5 * S, 32'sd0, 1'b1, pick_gap());
    // half-way rounding both directions
    send_point(32'd0, 32'sd0, 1'b0, pick_gap());
    send_point(2 * S, 32'sd1, 1'b0, pick_gap());
    send_point(4 * S, 32'sd0, 1'b0, pick_gap());
    send_point(4 * S, 32'sd5, 1'b1, pick_gap());
    // backward segment
    send_point(5 * S, 32'sd77, 1'b0, pick_gap());
    send_point(3 * S, -32'sd77, 1'b0, pick_gap());
    send_point(4 * S, 32'sh7FFF_FFFF, 1'b1, pick_gap());
    // saturation on steep extrapolation
    send_point(4 * S, 32'sh7FFF_FFFF, 1'b0, pick_gap());
    send_point(4 * S + 1, 32'sh8000_0000, 1'b0, pick_gap());
    send_point(9 * S, 32'sh7FFF_FFFF, 1'b1, pick_gap());
    send_point(4 * S, 32'sh8000_0000, 1'b0, pick_gap());
    send_point(4 * S + 1, 32'sh7FFF_FFFF, 1'b0, pick_gap());
    send_point(6 * S, 32'sd0, 1'b1, pick_gap());
    // full time range, sample limit
    send_point(32'd0, 32'sd12345, 1'b0, pick_gap());
    send_point(32'hFFFF_FFFF, -32'sd12345, 1'b1, pick_gap());
    send_point(32'hFFFF_FFFF, 32'sd1, 1'b0, pick_gap());
    send_point(32'hFFFF_FFFF, 32'sd2, 1'b1, pick_gap());
  endtask

  task automatic test_step_extremes();
    write_step(32'd0);
    send_point(32'd0, 32'sd100, 1'b0, pick_gap());
    send_point(32'd10, 32'sd1100, 1'b0, pick_gap());
    send_point(32'd200, -32'sd5000, 1'b0, pick_gap());
    send_point(32'd201, 32'sd7, 1'b1, pick_gap());
    write_step(32'd1);
    send_point(32'd5, -32'sd3, 1'b0, pick_gap());
    send_point(32'd9, 32'sd3, 1'b1, pick_gap());
    write_step(32'hFFFF_FFFF);
    send_point(32'd0, 32'sd0, 1'b0, pick_gap());
    send_point(32'd100, 32'sh7FFF_FFFF, 1'b0, pick_gap());
    send_point(32'hFFFF_FFFF, 32'sh8000_0000, 1'b0, pick_gap());
    send_point(32'hFFFF_FFFF, 32'sd5, 1'b1, pick_gap());
    send_point(32'hFFFF_FFFF, 32'sd100, 1'b0, pick_gap());
    send_point(32'hFFFF_FFFF, 32'sd200, 1'b1, pick_gap());
  endtask

  // output held off while breakpoints keep coming, then a full drain
  task automatic test_backpressure();
    write_step(S);
    hold_cycles = 600;
    send_curve(12, S, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_curves();
    logic [31:0] s;
    bit          burst;
    while (items_sent < NumItems) begin
      case ($urandom_range(0, 5))
        0:       s = S;
        1:       s = $urandom_range(1, 64);
        2:       s = $urandom_range(1000, 5_000_000);
        3:       s = $urandom;
        4:       s = 32'hFFFF_FFFF;
        default: s = 32'd1;
      endcase
      write_step(s);
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (items_sent >= NumItems) break;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3))
            send_point($urandom, $urandom, 1'($urandom_range(0, 1)), pick_gap());
        end
        send_curve($urandom_range(2, 8), s, burst);
      end
    end
  endtask

  // output side: random stalls, quiet stretches, and requested long holds
  initial begin
    int stall_left, quiet_left, r;
    out_stall  = 1'b0;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 20) stall_left = pick_gap() + 1;
          else if (r < 24) quiet_left = $urandom_range(30, 150);
        end
      end
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("unexpected word: value %0d run_end %0b overflow %0b",
                               smp_value, smp_run_end, smp_overflow));
      end else begin
        want = pending_samples.pop_front();
        words_checked++;
        if (smp_overflow) ovf_words++;
        if (smp_value !== want.value || smp_run_end !== want.last ||
            smp_overflow !== want.ovf)
          note_failure($sformatf(
            "word %0d mismatch: value %0d/%0d run_end %0b/%0b overflow %0b/%0b (exp/got)",
            words_checked, want.value, smp_value, want.last, smp_run_end,
            want.ovf, smp_overflow));
      end
    end
  end

  initial begin
    in_valid  = 1'b0;
    pt_time   = '0;
    pt_value  = '0;
    pt_final  = 1'b0;
    cfg_valid = 1'b0;
    cfg_step  = '0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_points();
    test_step_extremes();
    test_backpressure();
    test_random_curves();

    @(negedge clk);
    in_valid <= 1'b0;
    for (int i = 0; i < 400_000 && pending_samples.size() != 0; i++) @(posedge clk);
    repeat (Settle) @(posedge clk);
    if (pending_samples.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", pending_samples.size()));

    $display("Sent %0d breakpoints over %0d step settings; checked %0d words, %0d flagged.",
             items_sent, steps_written, words_checked, ovf_words);
    $display("Included single-point, backward and flat segments, saturation and long hold.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/liur_pkg.sv
rtl/linear_interp_uniform_resampler.sv
test/tb.sv
